// ===== hw/rtl/crrf_pkg.sv =====
// ----------------------------------------------------------------------------
// crrf_pkg
// Shared types and constants of the rounded rectangle fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crrf_pkg;

	localparam int COORD_BITS_DEF = 14;
	localparam int ADDR_BITS_DEF  = 48;

	localparam int FB_ADDR_W = 48;
	localparam int PITCH_W   = 16;
	localparam int DIM_W     = 13;
	localparam int RAD_W     = 12;
	localparam int COLOR_W   = 32;
	localparam int CNT_W     = 13;

	localparam int PADDR_W   = 6;
	localparam int PDATA_W   = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_PRESENT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BASE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PITCH   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT  = 3'd4;

	localparam logic REQ_CMD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CENTER,
		PH_LEFT,
		PH_RIGHT,
		PH_CORNER
	} phase_t;

	typedef struct packed {
		logic                 present;
		logic [FB_ADDR_W-1:0] base;
		logic [PITCH_W-1:0]   pitch;
		logic [DIM_W-1:0]     width;
		logic [DIM_W-1:0]     height;
	} fb_cfg_t;

	typedef struct packed {
		logic               valid;
		logic               wr;
		logic [DIM_W-1:0]   x;
		logic [DIM_W-1:0]   y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} walk_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clipped_rounded_rect_fill.sv =====
// ----------------------------------------------------------------------------
// clipped_rounded_rect_fill
// Rounded rectangle fill engine for a 32-bit linear framebuffer.
// ----------------------------------------------------------------------------
// A fill command (req_type 0) latches a rectangle and produces no result;
// every tick (req_type 1) produces one candidate pixel write: first the
// clipped center, left and right strips in row-major order, then the four
// corner diamonds, with last on the final candidate. One request is taken
// per clock unless in_stall is high; its result passes through the request
// register, the walk register and the address register. A stall on the
// result side holds all three stages, so in_stall follows out_stall while
// a result is waiting. The address is base + y*pitch + 4*x, formed by a
// single 13x16 multiply and add in the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rounded_rect_fill
	import crrf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [PADDR_W-1:0]           paddr,
	input  wire logic [PDATA_W-1:0]           pwdata,
	output logic      [PDATA_W-1:0]           prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         req_type,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic [DIM_W-1:0]             rect_w,
	input  wire logic [DIM_W-1:0]             rect_h,
	input  wire logic [RAD_W-1:0]             radius,
	input  wire logic [COLOR_W-1:0]           fill_color,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              write_valid,
	output logic [DIM_W-1:0]                  pixel_x,
	output logic [DIM_W-1:0]                  pixel_y,
	output logic [ADDR_BITS-1:0]              pixel_addr,
	output logic [COLOR_W-1:0]                pixel_color,
	output logic                              last
);

	fb_cfg_t   cfg;
	walk_res_t res_s2;
	logic      en;

	assign in_stall = !en;

	crrf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	crrf_walk #(
		.COORD_BITS(COORD_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.rect_w    (rect_w),
		.rect_h    (rect_h),
		.radius    (radius),
		.fill_color(fill_color),
		.res_s2    (res_s2)
	);

	crrf_addr #(
		.ADDR_BITS(ADDR_BITS)
	) u_addr (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_s2     (res_s2),
		.cfg        (cfg),
		.out_stall  (out_stall),
		.en         (en),
		.out_valid  (out_valid),
		.write_valid(write_valid),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.pixel_addr (pixel_addr),
		.pixel_color(pixel_color),
		.last       (last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/crrf_regs.sv =====
// ----------------------------------------------------------------------------
// crrf_regs
// Framebuffer description registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module crrf_regs
	import crrf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output fb_cfg_t                 cfg
);

	fb_cfg_t                cfg_q;
	logic [REG_IDX_W-1:0]   idx;
	logic                   wr_en;

	assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PRESENT: cfg_q.present <= pwdata[0];
				REG_BASE:    cfg_q.base    <= pwdata[FB_ADDR_W-1:0];
				REG_PITCH:   cfg_q.pitch   <= pwdata[PITCH_W-1:0];
				REG_WIDTH:   cfg_q.width   <= pwdata[DIM_W-1:0];
				REG_HEIGHT:  cfg_q.height  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PRESENT: prdata = PDATA_W'(cfg_q.present);
			REG_BASE:    prdata = PDATA_W'(cfg_q.base);
			REG_PITCH:   prdata = PDATA_W'(cfg_q.pitch);
			REG_WIDTH:   prdata = PDATA_W'(cfg_q.width);
			REG_HEIGHT:  prdata = PDATA_W'(cfg_q.height);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/crrf_clip.sv =====
// ----------------------------------------------------------------------------
// crrf_clip
// Clips one rectangle part against the framebuffer bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module crrf_clip
	import crrf_pkg::*;
#(
	parameter int SW = 16
) (
	input  wire logic                  present,
	input  wire logic [DIM_W-1:0]      fb_w,
	input  wire logic [DIM_W-1:0]      fb_h,
	input  wire logic signed [SW-1:0]  x,
	input  wire logic signed [SW-1:0]  y,
	input  wire logic signed [SW-1:0]  w,
	input  wire logic signed [SW-1:0]  h,
	output logic                       ok,
	output logic signed [SW-1:0]       x0,
	output logic signed [SW-1:0]       y0,
	output logic signed [SW-1:0]       x1,
	output logic signed [SW-1:0]       y1
);

	logic signed [SW-1:0] fbw_s;
	logic signed [SW-1:0] fbh_s;
	logic signed [SW-1:0] xe;
	logic signed [SW-1:0] ye;

	assign fbw_s = signed'({{(SW-DIM_W){1'b0}}, fb_w});
	assign fbh_s = signed'({{(SW-DIM_W){1'b0}}, fb_h});
	assign xe    = x + w;
	assign ye    = y + h;

	assign x0 = (x < 0) ? '0 : x;
	assign y0 = (y < 0) ? '0 : y;
	assign x1 = (xe > fbw_s) ? fbw_s : xe;
	assign y1 = (ye > fbh_s) ? fbh_s : ye;
	assign ok = present && (x1 > x0) && (y1 > y0);

endmodule

`default_nettype wire

// ===== hw/rtl/crrf_walk.sv =====
// ----------------------------------------------------------------------------
// crrf_walk
// Request register, fill walk state and per-tick candidate pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module crrf_walk
	import crrf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire fb_cfg_t                      cfg,
	input  wire logic                         in_valid,
	input  wire logic                         req_type,
	input  wire logic signed [COORD_BITS-1:0] pos_x,
	input  wire logic signed [COORD_BITS-1:0] pos_y,
	input  wire logic [DIM_W-1:0]             rect_w,
	input  wire logic [DIM_W-1:0]             rect_h,
	input  wire logic [RAD_W-1:0]             radius,
	input  wire logic [COLOR_W-1:0]           fill_color,
	output walk_res_t                         res_s2
);

	localparam int SW = ((COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1) + 2;

	logic                         valid_s1;
	logic                         req_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic [DIM_W-1:0]             w_s1;
	logic [DIM_W-1:0]             h_s1;
	logic [RAD_W-1:0]             r_s1;
	logic [COLOR_W-1:0]           color_s1;

	phase_t                       phase_q;
	phase_t                       phase_n;
	logic signed [COORD_BITS-1:0] cmd_x_q;
	logic signed [COORD_BITS-1:0] cmd_y_q;
	logic [DIM_W-1:0]             cmd_w_q;
	logic [DIM_W-1:0]             cmd_h_q;
	logic [RAD_W-1:0]             cmd_r_q;
	logic [COLOR_W-1:0]           cmd_color_q;
	logic [CNT_W-1:0]             row_q;
	logic [CNT_W-1:0]             col_q;
	logic [1:0]                   sel_q;
	logic [CNT_W-1:0]             row_n;
	logic [CNT_W-1:0]             col_n;
	logic [1:0]                   sel_n;

	logic                         is_cmd;
	logic                         is_tick;
	logic [RAD_W-1:0]             r_a;
	logic [RAD_W-1:0]             r_b;
	logic signed [COORD_BITS-1:0] sx;
	logic signed [COORD_BITS-1:0] sy;
	logic signed [SW-1:0]         gx;
	logic signed [SW-1:0]         gy;
	logic signed [SW-1:0]         gw;
	logic signed [SW-1:0]         gh;
	logic signed [SW-1:0]         gr;

	logic signed [SW-1:0]         part_x [3];
	logic signed [SW-1:0]         part_y [3];
	logic signed [SW-1:0]         part_w [3];
	logic signed [SW-1:0]         part_h [3];
	logic [2:0]                   clip_ok;
	logic signed [SW-1:0]         cx0 [3];
	logic signed [SW-1:0]         cy0 [3];
	logic signed [SW-1:0]         cx1 [3];
	logic signed [SW-1:0]         cy1 [3];

	logic [2:0]                   phase_off;
	logic [1:0]                   cp;
	logic [1:0]                   start_idx;
	logic [1:0]                   pick;
	logic                         found;
	logic                         do_enter;

	logic signed [SW-1:0]         col_s;
	logic signed [SW-1:0]         row_s;
	logic signed [SW-1:0]         col_inc;
	logic signed [SW-1:0]         row_inc;
	logic                         rect_hit;
	logic                         rect_wrap;
	logic signed [SW-1:0]         rect_col;
	logic signed [SW-1:0]         rect_row;
	logic                         rect_end;

	logic signed [SW-1:0]         dy;
	logic signed [SW-1:0]         ady;
	logic signed [SW-1:0]         span;
	logic signed [SW-1:0]         dx;
	logic signed [SW-1:0]         bx;
	logic signed [SW-1:0]         by;
	logic signed [SW-1:0]         cpx;
	logic signed [SW-1:0]         cpy;
	logic signed [SW-1:0]         fbw_s;
	logic signed [SW-1:0]         fbh_s;
	logic                         corner_hit;
	logic                         col_end;
	logic                         row_end;

	walk_res_t                    res_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1   <= req_type;
			x_s1     <= pos_x;
			y_s1     <= pos_y;
			w_s1     <= rect_w;
			h_s1     <= rect_h;
			r_s1     <= radius;
			color_s1 <= fill_color;
		end
	end

	assign is_cmd  = valid_s1 && (req_s1 == REQ_CMD);
	assign is_tick = valid_s1 && (req_s1 == REQ_TICK);

	assign r_a = ({1'b0, r_s1} << 1 > {1'b0, w_s1}) ? w_s1[DIM_W-1:1] : r_s1;
	assign r_b = ({1'b0, r_a} << 1 > {1'b0, h_s1}) ? h_s1[DIM_W-1:1] : r_a;

	assign sx = is_cmd ? x_s1 : cmd_x_q;
	assign sy = is_cmd ? y_s1 : cmd_y_q;
	assign gx = {{(SW-COORD_BITS){sx[COORD_BITS-1]}}, sx};
	assign gy = {{(SW-COORD_BITS){sy[COORD_BITS-1]}}, sy};
	assign gw = signed'({{(SW-DIM_W){1'b0}}, (is_cmd ? w_s1 : cmd_w_q)});
	assign gh = signed'({{(SW-DIM_W){1'b0}}, (is_cmd ? h_s1 : cmd_h_q)});
	assign gr = signed'({{(SW-RAD_W){1'b0}}, (is_cmd ? r_b : cmd_r_q)});

	assign part_x[0] = gx + gr;
	assign part_y[0] = gy;
	assign part_w[0] = gw - gr - gr;
	assign part_h[0] = gh;
	assign part_x[1] = gx;
	assign part_y[1] = gy + gr;
	assign part_w[1] = gr;
	assign part_h[1] = gh - gr - gr;
	assign part_x[2] = gx + gw - gr;
	assign part_y[2] = gy + gr;
	assign part_w[2] = gr;
	assign part_h[2] = gh - gr - gr;

	for (genvar i = 0; i < 3; i++) begin : g_clip
		crrf_clip #(
			.SW(SW)
		) u_clip (
			.present(cfg.present),
			.fb_w   (cfg.width),
			.fb_h   (cfg.height),
			.x      (part_x[i]),
			.y      (part_y[i]),
			.w      (part_w[i]),
			.h      (part_h[i]),
			.ok     (clip_ok[i]),
			.x0     (cx0[i]),
			.y0     (cy0[i]),
			.x1     (cx1[i]),
			.y1     (cy1[i])
		);
	end

	assign phase_off = phase_q - PH_CENTER;
	assign cp        = phase_off[1:0];
	assign start_idx = is_cmd ? 2'd0 : cp + 2'd1;

	always_comb begin
		pick  = 2'd0;
		found = 1'b0;
		for (int i = 2; i >= 0; i--) begin
			if ((2'(i) >= start_idx) && clip_ok[i]) begin
				pick  = 2'(i);
				found = 1'b1;
			end
		end
	end

	assign fbw_s = signed'({{(SW-DIM_W){1'b0}}, cfg.width});
	assign fbh_s = signed'({{(SW-DIM_W){1'b0}}, cfg.height});

	assign col_s    = signed'({{(SW-CNT_W){1'b0}}, col_q});
	assign row_s    = signed'({{(SW-CNT_W){1'b0}}, row_q});
	assign col_inc  = col_s + SW'(1);
	assign row_inc  = row_s + SW'(1);
	assign rect_hit = cfg.present && (col_q < cfg.width) && (row_q < cfg.height);
	assign rect_wrap = col_inc >= cx1[cp];
	assign rect_col = rect_wrap ? cx0[cp] : col_inc;
	assign rect_row = rect_wrap ? row_inc : row_s;
	assign rect_end = rect_row >= cy1[cp];

	assign dy   = row_s - gr;
	assign ady  = (dy < 0) ? -dy : dy;
	assign span = gr - ady;
	assign dx   = col_s - span;
	assign bx   = sel_q[0] ? gx + gw - gr - SW'(1) : gx + gr;
	assign by   = sel_q[1] ? gy + gh - gr - SW'(1) : gy + gr;
	assign cpx  = bx + dx;
	assign cpy  = by + dy;
	assign corner_hit = cfg.present && (cpx >= 0) && (cpy >= 0) &&
		(cpx < fbw_s) && (cpy < fbh_s);
	assign col_end = col_inc > span + span;
	assign row_end = row_inc > gr + gr;

	always_comb begin
		phase_n   = phase_q;
		row_n     = row_q;
		col_n     = col_q;
		sel_n     = sel_q;
		do_enter  = 1'b0;
		res_n     = '0;
		res_n.valid = is_tick;
		if (is_cmd) begin
			do_enter = 1'b1;
		end else if (is_tick) begin
			case (phase_q)
				PH_CENTER, PH_LEFT, PH_RIGHT: begin
					if (rect_hit) begin
						res_n.wr    = 1'b1;
						res_n.x     = col_q;
						res_n.y     = row_q;
						res_n.color = cmd_color_q;
					end
					if (!clip_ok[cp] || rect_end) begin
						do_enter = 1'b1;
					end else begin
						col_n = rect_col[CNT_W-1:0];
						row_n = rect_row[CNT_W-1:0];
					end
				end
				PH_CORNER: begin
					if (corner_hit) begin
						res_n.wr    = 1'b1;
						res_n.x     = cpx[DIM_W-1:0];
						res_n.y     = cpy[DIM_W-1:0];
						res_n.color = cmd_color_q;
					end
					sel_n = sel_q + 2'd1;
					if (sel_q == 2'd3) begin
						if (col_end) begin
							col_n = '0;
							if (row_end) begin
								row_n      = '0;
								phase_n    = PH_IDLE;
								res_n.last = 1'b1;
							end else begin
								row_n = row_inc[CNT_W-1:0];
							end
						end else begin
							col_n = col_inc[CNT_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
		if (do_enter) begin
			if (found) begin
				case (pick)
					2'd0:    phase_n = PH_CENTER;
					2'd1:    phase_n = PH_LEFT;
					default: phase_n = PH_RIGHT;
				endcase
				col_n = cx0[pick][CNT_W-1:0];
				row_n = cy0[pick][CNT_W-1:0];
			end else begin
				phase_n = PH_CORNER;
				col_n   = '0;
				row_n   = '0;
				sel_n   = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cmd_x_q     <= '0;
			cmd_y_q     <= '0;
			cmd_w_q     <= '0;
			cmd_h_q     <= '0;
			cmd_r_q     <= '0;
			cmd_color_q <= '0;
			row_q       <= '0;
			col_q       <= '0;
			sel_q       <= '0;
			res_s2      <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			row_q   <= row_n;
			col_q   <= col_n;
			sel_q   <= sel_n;
			res_s2  <= res_n;
			if (is_cmd) begin
				cmd_x_q     <= x_s1;
				cmd_y_q     <= y_s1;
				cmd_w_q     <= w_s1;
				cmd_h_q     <= h_s1;
				cmd_r_q     <= r_b;
				cmd_color_q <= color_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/crrf_addr.sv =====
// ----------------------------------------------------------------------------
// crrf_addr
// Pixel address generation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crrf_addr
	import crrf_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire walk_res_t            res_s2,
	input  wire fb_cfg_t              cfg,
	input  wire logic                 out_stall,
	output logic                      en,
	output logic                      out_valid,
	output logic                      write_valid,
	output logic [DIM_W-1:0]          pixel_x,
	output logic [DIM_W-1:0]          pixel_y,
	output logic [ADDR_BITS-1:0]      pixel_addr,
	output logic [COLOR_W-1:0]        pixel_color,
	output logic                      last
);

	localparam int AW = (ADDR_BITS > FB_ADDR_W) ? ADDR_BITS : FB_ADDR_W;

	logic [DIM_W+PITCH_W-1:0] row_off;
	logic [AW-1:0]            sum;
	logic [AW-1:0]            masked;
	logic                     out_valid_q;

	assign en      = !out_valid_q || !out_stall;
	assign row_off = res_s2.y * cfg.pitch;
	assign sum     = AW'(cfg.base) + AW'(row_off) + AW'({res_s2.x, 2'b00});
	assign masked  = sum & AW'({FB_ADDR_W{1'b1}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			write_valid <= res_s2.wr;
			pixel_x     <= res_s2.x;
			pixel_y     <= res_s2.y;
			pixel_addr  <= res_s2.wr ? masked[ADDR_BITS-1:0] : '0;
			pixel_color <= res_s2.color;
			last        <= res_s2.last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/crrf_checker.sv =====
// ----------------------------------------------------------------------------
// crrf_checker
// Port-level checks of the fill engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crrf_checker
	import crrf_pkg::*;
#(
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 write_valid,
	input wire logic [DIM_W-1:0]     pixel_x,
	input wire logic [DIM_W-1:0]     pixel_y,
	input wire logic [ADDR_BITS-1:0] pixel_addr,
	input wire logic [COLOR_W-1:0]   pixel_color,
	input wire logic                 last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(write_valid) &&
		$stable(pixel_addr) && $stable(pixel_color) && $stable(last))
		else $error("result changed while stalled");

	a_clipped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> pixel_x == '0 && pixel_y == '0 &&
		pixel_addr == '0 && pixel_color == '0)
		else $error("clipped candidate carries nonzero payload");

	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("request stalled with empty result register");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without result backpressure");

endmodule

bind clipped_rounded_rect_fill crrf_checker #(
	.ADDR_BITS (ADDR_BITS)
) u_crrf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.write_valid(write_valid),
	.pixel_x    (pixel_x),
	.pixel_y    (pixel_y),
	.pixel_addr (pixel_addr),
	.pixel_color(pixel_color),
	.last       (last)
);

`default_nettype wire
